/* rtl/ipv4_prefix_to_asn_lookup_core_assert.svh */
// ----------------------------------------------------------------------------
// ipv4 prefix lookup assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef IPV4_PREFIX_TO_ASN_LOOKUP_CORE_ASSERT_SVH
`define IPV4_PREFIX_TO_ASN_LOOKUP_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// property that must hold at every edge out of reset
`define IPLK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// same-cycle implication
`define IPLK_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define IPLK_ASSERT(lbl, clk, rst_n, prop, msg)
`define IPLK_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/iplk_pkg.sv */
// ----------------------------------------------------------------------------
// iplk_pkg
// shared types, widths and constants of the ipv4 prefix to asn lookup core
// ----------------------------------------------------------------------------
`default_nettype none

package iplk_pkg;

  // table geometry
  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  // field widths
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned ASN_W  = 32;
  localparam int unsigned ENTRY_W = ADDR_W + LEN_W + ASN_W;

  // constants
  localparam logic [ASN_W-1:0] MISS_ASN = 32'hFFFF_FFFF;
  localparam logic [LEN_W-1:0] MAX_LEN  = 6'd32;
  localparam logic [LEN_W-1:0] ZERO_LEN = 6'd0;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // operation codes
  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_e;

  // status codes
  typedef enum logic {
    STATUS_DONE = 1'b0,
    STATUS_FULL = 1'b1
  } status_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // one stored table entry
  typedef struct packed {
    logic [ADDR_W-1:0] key;
    logic [LEN_W-1:0]  len;
    logic [ASN_W-1:0]  asn;
  } entry_t;

  // flags from the compare unit
  typedef struct packed {
    logic exact;   // same length and same key
    logic prefix;  // masked address equals key, length 1 to 32
  } match_t;

  // network mask for a prefix length, zero for length 0 or above 32
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] mask;
    mask = '0;
    if (len != ZERO_LEN && len <= MAX_LEN) begin
      mask = {ADDR_W{1'b1}} << (MAX_LEN - len);
    end
    return mask;
  endfunction

endpackage

`default_nettype wire

/* rtl/iplk_req_if.sv */
// ----------------------------------------------------------------------------
// iplk_req_if
// request channel: lookup or insert word with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface iplk_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] address;
  logic [5:0]  prefix_length;
  logic [31:0] origin_asn;

  modport source (
    output valid, operation, address, prefix_length, origin_asn,
    input  ready
  );

  modport sink (
    input  valid, operation, address, prefix_length, origin_asn,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/iplk_rsp_if.sv */
// ----------------------------------------------------------------------------
// iplk_rsp_if
// response channel: one result word per request with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface iplk_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] result_asn;
  logic        status;

  modport source (
    output valid, found, result_asn, status,
    input  ready
  );

  modport sink (
    input  valid, found, result_asn, status,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/iplk_ram.sv */
// ----------------------------------------------------------------------------
// iplk_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module iplk_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/iplk_match.sv */
// ----------------------------------------------------------------------------
// iplk_match
// shared compare unit: masks the request address to a stored length and
// compares it with the stored key, also checks for an exact key/length hit
// ----------------------------------------------------------------------------
`default_nettype none

module iplk_match (
  input  wire logic [iplk_pkg::ADDR_W-1:0] addr_i,
  input  wire logic [iplk_pkg::LEN_W-1:0]  len_i,
  input  wire iplk_pkg::entry_t            entry_i,
  output iplk_pkg::match_t                 match_o
);

  logic [iplk_pkg::ADDR_W-1:0] masked;
  logic                        len_ok;

  // mask to the entry length, length 0 never matches
  assign masked = addr_i & iplk_pkg::prefix_mask(entry_i.len);
  assign len_ok = (entry_i.len != iplk_pkg::ZERO_LEN) && (entry_i.len <= iplk_pkg::MAX_LEN);

  assign match_o.prefix = len_ok && (masked == entry_i.key);
  assign match_o.exact  = (entry_i.len == len_i) && (entry_i.key == addr_i);

endmodule

`default_nettype wire

/* rtl/ipv4_prefix_to_asn_lookup_core.sv */
// ----------------------------------------------------------------------------
// ipv4_prefix_to_asn_lookup_core
// longest prefix match table from ipv4 prefixes to as numbers
// ----------------------------------------------------------------------------
//  channel | dir | modport | word
//  --------+-----+---------+--------------------------------------------------
//  req_i   | in  | sink    | operation, address, prefix_length, origin_asn
//  rsp_o   | out | source  | found, result_asn, status
//
//  a request walks the filled entries one per cycle through the single ram
//  read port and the shared compare unit; the finish state then loads the
//  result register (on an empty table the walk is empty), used entries at
//  most TABLE_ENTRIES; an insert with length above 32 skips the walk
//  reset clears the fill count, state and valid flags; no clearing pass over the ram
//  a result that is not taken holds the sequencer in its finish state; the
//  next request is accepted as soon as the result register is loaded
// ----------------------------------------------------------------------------
`default_nettype none

`include "ipv4_prefix_to_asn_lookup_core_assert.svh"

module ipv4_prefix_to_asn_lookup_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  iplk_req_if.sink   req_i,
  iplk_rsp_if.source rsp_o
);

  localparam int unsigned IDX_W = iplk_pkg::IDX_W;
  localparam int unsigned CNT_W = iplk_pkg::CNT_W;

  iplk_pkg::state_e state_q, state_d;

  // request registers
  iplk_pkg::op_e               op_q, op_d;
  logic [iplk_pkg::ADDR_W-1:0] addr_q, addr_d;
  logic [iplk_pkg::LEN_W-1:0]  len_q, len_d;
  logic [iplk_pkg::ASN_W-1:0]  asn_q, asn_d;
  logic                        ignore_q, ignore_d;

  // scan state
  logic [CNT_W-1:0] used_q, used_d;
  logic [CNT_W-1:0] issue_q, issue_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] pend_idx_q, pend_idx_d;
  logic             hit_q, hit_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
  logic [iplk_pkg::LEN_W-1:0] best_len_q, best_len_d;
  logic [iplk_pkg::ASN_W-1:0] best_asn_q, best_asn_d;

  // result register
  logic                       rsp_valid_q, rsp_valid_d;
  logic                       rsp_found_q, rsp_found_d;
  logic [iplk_pkg::ASN_W-1:0] rsp_asn_q, rsp_asn_d;
  iplk_pkg::status_e          rsp_status_q, rsp_status_d;

  // ram and compare unit
  logic              rd_en;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  iplk_pkg::entry_t  wr_entry;
  iplk_pkg::entry_t  rd_entry;
  iplk_pkg::match_t  match;

  iplk_ram #(
    .WIDTH (iplk_pkg::ENTRY_W),
    .DEPTH (iplk_pkg::TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (issue_q[IDX_W-1:0]),
    .rdata_o (rd_entry)
  );

  iplk_match u_match (
    .addr_i  (addr_q),
    .len_i   (len_q),
    .entry_i (rd_entry),
    .match_o (match)
  );

  // handshake and result ports
  assign req_i.ready      = (state_q == iplk_pkg::ST_IDLE);
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.found      = rsp_found_q;
  assign rsp_o.result_asn = rsp_asn_q;
  assign rsp_o.status     = rsp_status_q;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iplk_pkg::ST_IDLE;
      used_q      <= '0;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      pend_q      <= pend_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    addr_q       <= addr_d;
    len_q        <= len_d;
    asn_q        <= asn_d;
    ignore_q     <= ignore_d;
    issue_q      <= issue_d;
    pend_idx_q   <= pend_idx_d;
    hit_q        <= hit_d;
    hit_idx_q    <= hit_idx_d;
    best_len_q   <= best_len_d;
    best_asn_q   <= best_asn_d;
    rsp_found_q  <= rsp_found_d;
    rsp_asn_q    <= rsp_asn_d;
    rsp_status_q <= rsp_status_d;
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    addr_d       = addr_q;
    len_d        = len_q;
    asn_d        = asn_q;
    ignore_d     = ignore_q;
    used_d       = used_q;
    issue_d      = issue_q;
    pend_d       = 1'b0;
    pend_idx_d   = issue_q[IDX_W-1:0];
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    best_len_d   = best_len_q;
    best_asn_d   = best_asn_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_found_d  = rsp_found_q;
    rsp_asn_d    = rsp_asn_q;
    rsp_status_d = rsp_status_q;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = used_q[IDX_W-1:0];
    wr_entry     = '{key: addr_q, len: len_q, asn: asn_q};

    case (state_q)
      iplk_pkg::ST_IDLE: begin
        // capture the request word and clear the walk
        if (req_i.valid) begin
          op_d       = iplk_pkg::op_e'(req_i.operation);
          addr_d     = req_i.address;
          len_d      = req_i.prefix_length;
          asn_d      = req_i.origin_asn;
          ignore_d   = (req_i.operation == iplk_pkg::OP_INSERT) &&
                       (req_i.prefix_length > iplk_pkg::MAX_LEN);
          issue_d    = '0;
          hit_d      = 1'b0;
          best_len_d = iplk_pkg::ZERO_LEN;
          best_asn_d = iplk_pkg::MISS_ASN;
          state_d    = ignore_d ? iplk_pkg::ST_FINISH : iplk_pkg::ST_SCAN;
        end
      end

      iplk_pkg::ST_SCAN: begin
        // issue one read per cycle over the filled entries
        if (issue_q != used_q) begin
          rd_en   = 1'b1;
          pend_d  = 1'b1;
          issue_d = issue_q + iplk_pkg::CNT_ONE;
        end
        // evaluate the entry read in the previous cycle
        if (pend_q) begin
          if (op_q == iplk_pkg::OP_LOOKUP) begin
            if (match.prefix && (!hit_q || rd_entry.len > best_len_q)) begin
              hit_d      = 1'b1;
              best_len_d = rd_entry.len;
              best_asn_d = rd_entry.asn;
            end
          end else if (match.exact && !hit_q) begin
            hit_d     = 1'b1;
            hit_idx_d = pend_idx_q;
          end
        end
        if (issue_q == used_q && !pend_q) begin
          state_d = iplk_pkg::ST_FINISH;
        end
      end

      iplk_pkg::ST_FINISH: begin
        // load the result register once it is free, commit an insert
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          rsp_found_d  = 1'b0;
          rsp_asn_d    = iplk_pkg::MISS_ASN;
          rsp_status_d = iplk_pkg::STATUS_DONE;
          if (op_q == iplk_pkg::OP_LOOKUP) begin
            rsp_found_d = hit_q;
            rsp_asn_d   = hit_q ? best_asn_q : iplk_pkg::MISS_ASN;
          end else if (!ignore_q) begin
            if (hit_q) begin
              wr_en   = 1'b1;
              wr_addr = hit_idx_q;
            end else if (used_q == iplk_pkg::FULL_CNT) begin
              rsp_status_d = iplk_pkg::STATUS_FULL;
            end else begin
              wr_en  = 1'b1;
              used_d = used_q + iplk_pkg::CNT_ONE;
            end
          end
          state_d = iplk_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = iplk_pkg::ST_IDLE;
      end
    endcase
  end

  // assertions
  `IPLK_ASSERT(a_used_bound, clk_i, rst_ni, used_q <= iplk_pkg::FULL_CNT, "fill count overflow")
  `IPLK_ASSERT_IMPL(a_issue_bound, clk_i, rst_ni, state_q == iplk_pkg::ST_SCAN, issue_q <= used_q, "scan ran past fill count")
  `IPLK_ASSERT_IMPL(a_used_grows, clk_i, rst_ni, used_q != $past(used_q), $past(state_q == iplk_pkg::ST_FINISH) && used_q == $past(used_q) + iplk_pkg::CNT_ONE, "fill count moved outside commit")
  `IPLK_ASSERT_IMPL(a_full_status, clk_i, rst_ni, rsp_valid_q && rsp_status_q == iplk_pkg::STATUS_FULL, used_q == iplk_pkg::FULL_CNT && !rsp_found_q, "full status with room left")

endmodule

`default_nettype wire

/* sim/tb_ipv4_prefix_to_asn_lookup_core.sv */
// ----------------------------------------------------------------------------
// tb_ipv4_prefix_to_asn_lookup_core
// self-checking bench for the ipv4 prefix to asn lookup core: directed words
// cover empty table, longest match, odd inserts and a full table; random
// lookup and insert traffic runs under sender bursts and receiver stalls;
// every result word is checked against a local prefix table model
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ipv4_prefix_to_asn_lookup_core;
  timeunit 1ns;
  timeprecision 1ps;

  import iplk_pkg::*;

  // run limit in cycles, several times the slowest legal run
  localparam int unsigned RUN_LIMIT   = 10_000_000;
  localparam int unsigned RANDOM_WORDS = 560;
  localparam int unsigned MAX_PRINTS  = 40;

  // one expected result word
  typedef struct {
    logic        found;
    logic [31:0] asn;
    status_e     status;
  } lpm_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  iplk_req_if req_if ();
  iplk_rsp_if rsp_if ();

  ipv4_prefix_to_asn_lookup_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // local copy of the prefix table
  logic [31:0] tbl_key [TABLE_ENTRIES];
  logic [5:0]  tbl_len [TABLE_ENTRIES];
  logic [31:0] tbl_asn [TABLE_ENTRIES];
  int unsigned tbl_count;

  lpm_result_t pending_results [$];
  int unsigned err_count;
  int unsigned cycle_count;

  // traffic shaping knobs
  bit          tx_fast;
  bit          rx_fast;
  int unsigned tx_burst_left;
  int unsigned hold_left;
  int unsigned rx_span;
  int unsigned rx_style;

  // clock
  always #5 clk_i = ~clk_i;

  // network mask for a stored length, zero for length 0
  function automatic logic [31:0] net_mask(input logic [5:0] len);
    if (len == ZERO_LEN || len > MAX_LEN) return 32'h0;
    return 32'hFFFF_FFFF << (6'd32 - len);
  endfunction

  // longest prefix match and table update for one accepted word
  function automatic lpm_result_t lpm_predict(input op_e op, input logic [31:0] addr,
                                              input logic [5:0] len,
                                              input logic [31:0] asn);
    lpm_result_t r;
    logic [5:0]  best_len;
    int unsigned i;
    r.found  = 1'b0;
    r.asn    = MISS_ASN;
    r.status = STATUS_DONE;
    best_len = ZERO_LEN;
    if (op == OP_LOOKUP) begin
      for (i = 0; i < tbl_count; i++) begin
        if (tbl_len[i] != ZERO_LEN && (addr & net_mask(tbl_len[i])) == tbl_key[i] &&
            (!r.found || tbl_len[i] > best_len)) begin
          r.found  = 1'b1;
          best_len = tbl_len[i];
          r.asn    = tbl_asn[i];
        end
      end
      return r;
    end
    // oversized length is dropped
    if (len > MAX_LEN) return r;
    // same key and length: replace the asn, even when full
    for (i = 0; i < tbl_count; i++) begin
      if (tbl_len[i] == len && tbl_key[i] == addr) begin
        tbl_asn[i] = asn;
        return r;
      end
    end
    if (tbl_count >= TABLE_ENTRIES) begin
      r.status = STATUS_FULL;
      return r;
    end
    tbl_key[tbl_count] = addr;
    tbl_len[tbl_count] = len;
    tbl_asn[tbl_count] = asn;
    tbl_count++;
    return r;
  endfunction

  // one mismatch line, counted
  task automatic report_mismatch(input string what, input logic [31:0] exp_val,
                                 input logic [31:0] got_val);
    if (err_count < MAX_PRINTS)
      $display("[%0t] mismatch %s: expected %h got %h", $realtime, what, exp_val, got_val);
    err_count++;
  endtask

  // offer one request word and wait until it is taken
  task automatic send_word(input op_e op, input logic [31:0] addr, input logic [5:0] len,
                           input logic [31:0] asn);
    int unsigned gap;
    gap = 0;
    if (!tx_fast) begin
      if (tx_burst_left == 0) begin
        tx_burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      tx_burst_left--;
    end
    if (gap > 0) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_if.valid         <= 1'b1;
    req_if.operation     <= op;
    req_if.address       <= addr;
    req_if.prefix_length <= len;
    req_if.origin_asn    <= asn;
    do @(posedge clk_i); while (!req_if.ready);
    pending_results.push_back(lpm_predict(op, addr, len, asn));
  endtask

  // drop valid and wait for every outstanding result
  task automatic wait_results;
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // receiver stall pattern, with an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      hold_left--;
    end else if (rx_fast) begin
      rsp_if.ready <= 1'b1;
    end else begin
      if (rx_span == 0) begin
        rx_style = $urandom_range(0, 3);
        rx_span  = $urandom_range(8, 80);
      end
      rx_span--;
      case (rx_style)
        0: begin
          rsp_if.ready <= 1'b1;
        end
        1: begin
          rsp_if.ready <= 1'($urandom_range(0, 1));
        end
        2: begin
          rsp_if.ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          rsp_if.ready <= (rx_span % 3 != 0);
        end
      endcase
    end
  end

  // result word checker
  always @(posedge clk_i) begin
    lpm_result_t exp_res;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word, asn", 32'h0, rsp_if.result_asn);
      end else begin
        exp_res = pending_results.pop_front();
        if (rsp_if.found !== exp_res.found)
          report_mismatch("found", 32'(exp_res.found), 32'(rsp_if.found));
        if (rsp_if.result_asn !== exp_res.asn)
          report_mismatch("result_asn", exp_res.asn, rsp_if.result_asn);
        if (rsp_if.status !== exp_res.status)
          report_mismatch("status", 32'(exp_res.status), 32'(rsp_if.status));
      end
    end
  end

  // lookups and ignored inserts on an empty table
  task automatic test_empty_table;
    send_word(OP_LOOKUP, 32'h0000_0000, 6'd0, 32'h0);
    send_word(OP_LOOKUP, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
    send_word(OP_INSERT, 32'h0A00_0000, 6'd33, 32'h0000_1111);
    send_word(OP_LOOKUP, 32'h0A00_0000, 6'd8, 32'h0);
    wait_results();
  endtask

  // nested prefixes, the longest one wins
  task automatic test_longest_match;
    send_word(OP_INSERT, 32'h0A00_0000, 6'd8,  32'h0000_00A1);
    send_word(OP_INSERT, 32'h0A01_0000, 6'd16, 32'h0000_00B2);
    send_word(OP_INSERT, 32'h0A01_0200, 6'd24, 32'h0000_00C3);
    send_word(OP_INSERT, 32'h0A01_0203, 6'd32, 32'h0000_00D4);
    send_word(OP_LOOKUP, 32'h0A01_0203, 6'd0, 32'h0);
    send_word(OP_LOOKUP, 32'h0A01_0204, 6'd32, 32'h0);
    send_word(OP_LOOKUP, 32'h0A01_0301, 6'd0, 32'h0);
    send_word(OP_LOOKUP, 32'h0A02_0000, 6'd0, 32'h0);
    send_word(OP_LOOKUP, 32'h0B00_0000, 6'd0, 32'h0);
    send_word(OP_INSERT, 32'h8000_0000, 6'd1, 32'h0000_0000);
    send_word(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0);
    wait_results();
  endtask

  // zero length, host bits, overwrite, all-ones asn, oversized length
  task automatic test_special_inserts;
    send_word(OP_INSERT, 32'h0000_0000, 6'd0,  32'h0000_1234);
    send_word(OP_LOOKUP, 32'h0000_0000, 6'd0,  32'h0);
    send_word(OP_INSERT, 32'hC0A8_0101, 6'd24, 32'h0000_5678);
    send_word(OP_LOOKUP, 32'hC0A8_0101, 6'd0,  32'h0);
    send_word(OP_INSERT, 32'h0A01_0000, 6'd16, 32'h0000_00E5);
    send_word(OP_LOOKUP, 32'h0A01_0909, 6'd0,  32'h0);
    send_word(OP_INSERT, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF);
    send_word(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0,  32'h0);
    send_word(OP_INSERT, 32'h0A01_0200, 6'd63, 32'h0000_0999);
    wait_results();
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_long_hold;
    tx_fast   = 1'b1;
    hold_left = 300;
    send_word(OP_LOOKUP, 32'h0A01_0203, 6'd0,  32'h0);
    send_word(OP_INSERT, 32'h0A01_0280, 6'd25, 32'h0000_0777);
    send_word(OP_LOOKUP, 32'h0A01_0281, 6'd0,  32'h0);
    send_word(OP_LOOKUP, 32'h0A7F_0000, 6'd0,  32'h0);
    send_word(OP_INSERT, 32'h0A01_0200, 6'd24, 32'h0000_0888);
    send_word(OP_LOOKUP, 32'h0A01_0210, 6'd0,  32'h0);
    wait_results();
    tx_fast = 1'b0;
  endtask

  // mostly well-formed prefixes around a few bases, with noise
  task automatic test_random_traffic;
    logic [31:0] bases [8];
    logic [31:0] addr;
    logic [31:0] m;
    logic [5:0]  len;
    int unsigned idx;
    int unsigned pick;
    int unsigned n;
    foreach (bases[k]) bases[k] = $urandom;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // well-formed prefix off a shared base
        len  = 6'($urandom_range(1, 32));
        addr = ($urandom_range(0, 9) == 0) ? $urandom : bases[$urandom_range(0, 7)];
        send_word(OP_INSERT, addr & net_mask(len), len, $urandom);
      end else if (pick < 45 && tbl_count > 0) begin
        // overwrite of a stored entry
        idx = $urandom_range(0, tbl_count - 1);
        send_word(OP_INSERT, tbl_key[idx], tbl_len[idx], $urandom);
      end else if (pick < 85) begin
        // lookup under a stored prefix or a base
        if (tbl_count > 0 && $urandom_range(0, 3) != 0) begin
          idx  = $urandom_range(0, tbl_count - 1);
          m    = net_mask(tbl_len[idx]);
          addr = tbl_key[idx] | ($urandom & ~m);
        end else begin
          addr = bases[$urandom_range(0, 7)] ^ (32'hFFFF_FFFF >> $urandom_range(0, 31));
        end
        send_word(OP_LOOKUP, addr, 6'($urandom_range(0, 63)), $urandom);
      end else if (pick < 90) begin
        send_word(OP_LOOKUP, $urandom, 6'($urandom_range(0, 63)), $urandom);
      end else begin
        // zero length, oversized length or host bits set
        case ($urandom_range(0, 2))
          0: len = ZERO_LEN;
          1: len = 6'($urandom_range(33, 63));
          default: len = 6'($urandom_range(1, 31));
        endcase
        send_word(OP_INSERT, $urandom | 32'h1, len, $urandom);
      end
    end
    wait_results();
  endtask

  // fill every slot, then full rejection and overwrite while full
  task automatic test_full_table;
    int unsigned idx;
    tx_fast = 1'b1;
    rx_fast = 1'b1;
    while (tbl_count < TABLE_ENTRIES) send_word(OP_INSERT, $urandom, 6'd32, $urandom);
    wait_results();
    tx_fast = 1'b0;
    rx_fast = 1'b0;
    idx = $urandom_range(0, TABLE_ENTRIES - 1);
    send_word(OP_INSERT, 32'h0102_0300, 6'd24, 32'h0000_0ABC);
    send_word(OP_INSERT, tbl_key[idx], tbl_len[idx], 32'h0000_0DEF);
    send_word(OP_LOOKUP, tbl_key[idx], 6'd0, 32'h0);
    send_word(OP_INSERT, 32'h0102_0300, 6'd40, 32'h0000_0ABC);
    send_word(OP_INSERT, 32'h0000_0000, ZERO_LEN, 32'h0000_0001);
    send_word(OP_LOOKUP, 32'h0A01_0203, 6'd0, 32'h0);
    send_word(OP_LOOKUP, $urandom, 6'd0, 32'h0);
    wait_results();
  endtask

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // sequence of tests
  initial begin
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.operation     = OP_LOOKUP;
    req_if.address       = 32'h0;
    req_if.prefix_length = 6'd0;
    req_if.origin_asn    = 32'h0;
    rsp_if.ready         = 1'b0;
    tbl_count     = 0;
    err_count     = 0;
    tx_fast       = 1'b0;
    rx_fast       = 1'b0;
    tx_burst_left = 0;
    hold_left     = 0;
    rx_span       = 0;
    rx_style      = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_longest_match();
    test_special_inserts();
    test_long_hold();
    test_random_traffic();
    test_full_table();

    // let any stray word show up
    repeat (TABLE_ENTRIES + 16) @(posedge clk_i);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
